// File: sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Lead byte ranges for two, three and four byte sequences.
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // Mask applied to a byte that is passed through on its own.
  localparam logic [7:0] ASCII_MASK = 8'h7F;

  // Sequence lengths in bytes.
  localparam logic [2:0] LEN1 = 3'd1;
  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

  localparam int CP_W    = 21;
  localparam int ACCUM_W = 18;

  // One decoded result.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [2:0]      seq_bytes;
    logic            truncated;
  } res_t;

endpackage

// File: sv/u8d_core.sv
// ----------------------------------------------------------------------------
// u8d_core
// Sequence state and combinational decode of one byte per transaction.
// ----------------------------------------------------------------------------
module u8d_core
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  output logic       res_vld,
  output res_t       res
);

  logic [1:0]         bytes_left_r, bytes_left_nxt;
  logic [2:0]         seen_r, seen_nxt;
  logic [4:0]         lead_r, lead_nxt;
  logic [ACCUM_W-1:0] accum_r, accum_nxt;

  logic [1:0]         conts;
  logic [ACCUM_W-1:0] acc_shift;
  logic [1:0]         left_dec;
  logic [2:0]         seen_inc;
  logic [CP_W-1:0]    lead_part;

  // Next state and result for the byte on the input.
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    seen_nxt       = seen_r;
    lead_nxt       = lead_r;
    accum_nxt      = accum_r;
    res_vld        = 1'b0;
    res            = '0;
    lead_part      = '0;

    acc_shift = {accum_r[ACCUM_W-7:0], in_byte[5:0]};
    left_dec  = bytes_left_r - 2'd1;
    seen_inc  = seen_r + 3'd1;

    // Classify a potential lead byte.
    if (in_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
      conts = 2'd1;
    end else if (in_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
      conts = 2'd2;
    end else if (in_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
      conts = 2'd3;
    end else begin
      conts = 2'd0;
    end

    // Lead bits placed above the payload, by the length actually consumed.
    case (seen_inc)
      LEN2:    lead_part = {10'd0, lead_r[4:0], 6'd0};
      LEN3:    lead_part = {5'd0, lead_r[3:0], 12'd0};
      LEN4:    lead_part = {lead_r[2:0], 18'd0};
      default: lead_part = '0;
    endcase

    if (take) begin
      if (bytes_left_r == 2'd0) begin
        if (conts == 2'd0) begin
          // A byte outside any sequence passes through with its top bit cleared.
          res_vld        = 1'b1;
          res.code_point = {13'd0, in_byte & ASCII_MASK};
          res.seq_bytes  = LEN1;
          res.truncated  = 1'b0;
        end else begin
          // Open a new sequence.
          bytes_left_nxt = conts;
          seen_nxt       = LEN1;
          lead_nxt       = in_byte[4:0];
          accum_nxt      = '0;
        end
      end else if (in_byte == 8'd0 || left_dec == 2'd0) begin
        // The sequence ends here, either in full or cut short by a zero byte.
        res_vld        = 1'b1;
        res.code_point = lead_part | {3'd0, acc_shift};
        res.seq_bytes  = seen_inc;
        res.truncated  = (left_dec != 2'd0);
        bytes_left_nxt = 2'd0;
        seen_nxt       = 3'd0;
        accum_nxt      = '0;
      end else begin
        // Gather one more continuation byte.
        bytes_left_nxt = left_dec;
        seen_nxt       = seen_inc;
        accum_nxt      = acc_shift;
      end
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      seen_r       <= 3'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      seen_r       <= seen_nxt;
    end
    lead_r  <= lead_nxt;
    accum_r <= accum_nxt;
  end

  // With no sequence open, no byte count is carried.
  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r == 2'd0) |-> (seen_r == 3'd0))
    else $error("byte count held with no open sequence");

  // An open sequence never spans more than four bytes.
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != 2'd0) |-> (seen_r != 3'd0 && ({1'b0, seen_r} + {2'b0, bytes_left_r}) <= 4'd4))
    else $error("open sequence longer than four bytes");

endmodule

// File: sv/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream decoder with a two-entry result buffer.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while results are taken; each byte is decoded
// in the cycle it is accepted, and a result, when the byte ends a sequence
// or stands alone, is registered in the output register, or in the skid
// entry if that is held. The output register plus one skid entry let the
// input keep moving while the output is stalled, until one more result is
// waiting in the skid entry; in_stall is then raised and drops again in the
// cycle after the held output is taken. Continuation bytes are not checked;
// a zero byte ends an open sequence early and flags it truncated.
module utf8_stream_decoder_top
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic [2:0]      out_seq_bytes,
  output logic            out_truncated
);

  logic take;
  logic res_vld;
  res_t res;
  logic pop;

  logic out_valid_r;
  res_t out_r;
  logic skid_valid_r;
  res_t skid_r;

  // Input transaction: taken whenever the skid entry is free.
  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign pop      = out_valid_r && !out_stall;

  u8d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  // Output register and skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_r.code_point;
  assign out_seq_bytes  = out_r.seq_bytes;
  assign out_truncated  = out_r.truncated;

  // The skid entry is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // A result that meets a stalled output waits in the skid entry.
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && res_vld) |=> skid_valid_r)
    else $error("result lost while output stalled");

  // A truncated sequence is two or three bytes long.
  a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.truncated) |-> (out_r.seq_bytes == LEN2 || out_r.seq_bytes == LEN3))
    else $error("truncated flag with impossible length");

  // A single-byte result is always seven bits wide.
  a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.seq_bytes == LEN1) |-> (out_r.code_point[CP_W-1:7] == '0))
    else $error("single byte result wider than seven bits");

endmodule
